/* hw/rtl/soht_pkg.sv */
package soht_pkg;

    localparam int SOHT_NUM_BUCKETS  = 256;
    localparam int SOHT_BUCKET_DEPTH = 8;
    localparam int KEY_BYTES         = 8;
    localparam int KEY_W             = 8 * KEY_BYTES;
    localparam int LEN_W             = 4;
    localparam int VALUE_BITS        = 32;
    localparam int CFG_W             = 4;
    localparam int CFG_IDX_W         = 2;
    localparam int HASH_W            = 10;
    localparam int HASH_ODD_ADD      = 1 << 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_CAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REORDER    = 2'd2;

    localparam logic [1:0] MODE_TO_FRONT = 2'd1;
    localparam logic [1:0] MODE_UP_ONE   = 2'd2;

    localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 4'd8;

    typedef enum logic [1:0] {
        ACT_INSERT  = 2'd0,
        ACT_GET     = 2'd1,
        ACT_REPLACE = 2'd2,
        ACT_REMOVE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        RS_DONE        = 3'd0,
        RS_NOT_FOUND   = 3'd1,
        RS_DUPLICATE   = 3'd2,
        RS_TABLE_FULL  = 3'd3,
        RS_BUCKET_FULL = 3'd4
    } res_status_t;

    typedef struct packed {
        action_t                action;
        logic [KEY_W-1:0]       key_chars;
        logic [LEN_W-1:0]       key_length;
        logic [VALUE_BITS-1:0]  value_in;
    } req_t;

    typedef struct packed {
        res_status_t            status;
        logic [VALUE_BITS-1:0]  value_out;
        logic                   evicted;
    } res_t;

    typedef struct packed {
        logic [KEY_W-1:0]       key;
        logic [LEN_W-1:0]       len;
        logic [VALUE_BITS-1:0]  value;
    } entry_t;

    typedef struct packed {
        logic       hash_done;
        logic       match;
        logic       at_end;
        logic       at_lo;
        logic       at_last;
        logic       table_full;
        logic       bucket_full;
        logic       reorder;
        action_t    action;
    } dp_stat_t;

    typedef struct packed {
        logic           load;
        logic           hash_step;
        logic           hash;
        logic           fill_cap;
        logic           cur_clr;
        logic           cur_inc;
        logic           cur_dec;
        logic           rd_cur;
        logic           rd_prev;
        logic           rd_next;
        logic           wr_cur;
        logic           put;
        logic           hit_cap;
        logic           setup_hit;
        logic           setup_ins;
        logic           fin;
        res_status_t    status;
    } dp_cmd_t;

    function automatic logic [7:0] soht_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] soht_len_clamp(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] r;
        r = len;
        if (len == '0)
        begin
            r = LEN_W'(1);
        end
        else if (int'(len) > KEY_BYTES)
        begin
            r = LEN_W'(KEY_BYTES);
        end
        return r;
    endfunction

    function automatic logic [KEY_W-1:0] soht_key_mask(input logic [KEY_W-1:0] key,
                                                      input logic [LEN_W-1:0] len);
        logic [KEY_W-1:0] r;
        r = key;
        for (int i = 0; i < KEY_BYTES; i++)
        begin
            if (i >= int'(len))
            begin
                r[8*i +: 8] = 8'h00;
            end
        end
        return r;
    endfunction

endpackage

/* hw/rtl/soht_ctrl.sv */
module soht_ctrl
    import soht_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy
);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_HASH    = 11'b000_0000_0010,
        S_FILL    = 11'b000_0000_0100,
        S_SRCH_RD = 11'b000_0000_1000,
        S_SRCH_CM = 11'b000_0001_0000,
        S_HIT     = 11'b000_0010_0000,
        S_SHDN_RD = 11'b000_0100_0000,
        S_SHDN_WR = 11'b000_1000_0000,
        S_SHUP_RD = 11'b001_0000_0000,
        S_SHUP_WR = 11'b010_0000_0000,
        S_FIN     = 11'b100_0000_0000
    } state_t;

    state_t      state_reg, state_next;
    res_status_t status_reg, status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= RS_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.status  = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (!stat.hash_done)
                begin
                    cmd.hash_step = 1'b1;
                end
                else
                begin
                    cmd.hash   = 1'b1;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                cmd.fill_cap = 1'b1;
                if (stat.action == ACT_INSERT && stat.table_full)
                begin
                    status_next = RS_TABLE_FULL;
                    state_next  = S_FIN;
                end
                else
                begin
                    cmd.cur_clr = 1'b1;
                    state_next  = S_SRCH_RD;
                end
            end
            S_SRCH_RD:
            begin
                if (stat.at_end)
                begin
                    if (stat.action != ACT_INSERT)
                    begin
                        status_next = RS_NOT_FOUND;
                        state_next  = S_FIN;
                    end
                    else if (stat.bucket_full)
                    begin
                        status_next = RS_BUCKET_FULL;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        cmd.setup_ins = 1'b1;
                        status_next   = RS_DONE;
                        state_next    = S_SHDN_RD;
                    end
                end
                else
                begin
                    cmd.rd_cur = 1'b1;
                    state_next = S_SRCH_CM;
                end
            end
            S_SRCH_CM:
            begin
                if (stat.match)
                begin
                    cmd.hit_cap = 1'b1;
                    state_next  = S_HIT;
                end
                else
                begin
                    cmd.cur_inc = 1'b1;
                    state_next  = S_SRCH_RD;
                end
            end
            S_HIT:
            begin
                cmd.setup_hit = 1'b1;
                status_next   = (stat.action == ACT_INSERT) ? RS_DUPLICATE : RS_DONE;
                if (stat.action == ACT_REMOVE)
                begin
                    state_next = S_SHUP_RD;
                end
                else if (stat.reorder || stat.action == ACT_REPLACE)
                begin
                    state_next = S_SHDN_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_SHDN_RD:
            begin
                if (stat.at_lo)
                begin
                    cmd.put    = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = S_SHDN_WR;
                end
            end
            S_SHDN_WR:
            begin
                cmd.wr_cur  = 1'b1;
                cmd.cur_dec = 1'b1;
                state_next  = S_SHDN_RD;
            end
            S_SHUP_RD:
            begin
                if (stat.at_last)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                    state_next  = S_SHUP_WR;
                end
            end
            S_SHUP_WR:
            begin
                cmd.wr_cur  = 1'b1;
                cmd.cur_inc = 1'b1;
                state_next  = S_SHUP_RD;
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/soht_dp.sv */
module soht_dp
    import soht_pkg::*;
#(
    parameter int NUM_BUCKETS  = SOHT_NUM_BUCKETS,
    parameter int BUCKET_DEPTH = SOHT_BUCKET_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  req_t                  request,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    output logic                  done,
    output res_t                  result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int BW      = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int SLOTS   = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int SAW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FW      = $clog2(BUCKET_DEPTH + 1);
    localparam int CNTW    = $clog2(NUM_BUCKETS + 1);
    localparam int LOG2_NB = CNTW - 1;
    localparam int HEXT    = (BW > HASH_W) ? BW : HASH_W;
    localparam int CPW     = (FW > CFG_W) ? FW : CFG_W;
    localparam logic [SAW-1:0] DEPTH_S = SAW'(BUCKET_DEPTH);
    localparam logic [CPW-1:0] DEPTH_C = CPW'(BUCKET_DEPTH);

    entry_t                 entry_mem [SLOTS];
    logic [FW-1:0]          fill_mem  [NUM_BUCKETS];
    logic                   fill_vld_reg [NUM_BUCKETS];

    logic [CFG_W-1:0]       tsl_reg;
    logic [CFG_W-1:0]       cap_reg;
    logic [1:0]             mode_reg;
    logic [CNTW-1:0]        item_count_reg;
    logic                   done_reg;

    action_t                act_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [VALUE_BITS-1:0]  val_reg;
    logic [HASH_W-1:0]      hash_reg;
    logic [LEN_W-1:0]       hidx_reg;
    logic [BW-1:0]          bucket_reg;
    logic [SAW-1:0]         base_reg;
    logic [FW-1:0]          fill_reg;
    logic [FW-1:0]          fill_q_reg;
    logic                   vld_q_reg;
    logic [FW-1:0]          cursor_reg;
    logic [FW-1:0]          lo_reg;
    logic [FW-1:0]          pos_reg;
    entry_t                 held_reg;
    logic [VALUE_BITS-1:0]  old_val_reg;
    entry_t                 rd_data_reg;
    res_t                   res_reg;

    logic [LEN_W-1:0]       len_in;
    logic [7:0]             hash_byte;
    logic [HEXT-1:0]        hash_ext;
    logic [3:0]             lg;
    logic [BW-1:0]          bucket_c;
    logic [CNTW-1:0]        size_c;
    logic [CPW-1:0]         cap_eff;
    logic [CPW-1:0]         fill_ext;
    logic                   evict;
    logic [FW-1:0]          keep;
    logic                   mem_we;
    logic                   mem_re;
    logic [SAW-1:0]         wr_addr;
    logic [SAW-1:0]         rd_addr;
    entry_t                 wr_data;
    logic                   commit;
    logic [FW-1:0]          fill_new;

    assign len_in    = soht_len_clamp(request.key_length);
    assign hash_byte = key_reg[{hidx_reg[2:0], 3'b000} +: 8];
    assign hash_ext  = HEXT'(hash_reg);
    assign lg        = (int'(tsl_reg) > LOG2_NB) ? 4'(LOG2_NB) : tsl_reg;
    assign size_c    = CNTW'(1) << lg;

    always_comb
    begin
        for (int b = 0; b < BW; b++)
        begin
            bucket_c[b] = hash_ext[b] & (b < int'(lg));
        end
    end

    assign cap_eff  = (CPW'(cap_reg) > DEPTH_C) ? DEPTH_C : CPW'(cap_reg);
    assign fill_ext = CPW'(fill_reg);
    assign evict    = (cap_eff != '0) && (fill_ext >= cap_eff);
    assign keep     = evict ? fill_reg - FW'(1) : fill_reg;

    assign stat.hash_done   = (hidx_reg >= len_reg);
    assign stat.match       = (rd_data_reg.len == len_reg) && (rd_data_reg.key == key_reg);
    assign stat.at_end      = (cursor_reg == fill_reg);
    assign stat.at_lo       = (cursor_reg == lo_reg);
    assign stat.at_last     = ({1'b0, cursor_reg} + (FW+1)'(1)) >= {1'b0, fill_reg};
    assign stat.table_full  = (item_count_reg >= size_c);
    assign stat.bucket_full = (cap_eff == '0) && (fill_ext >= DEPTH_C);
    assign stat.reorder     = (pos_reg != '0)
                              && (mode_reg == MODE_TO_FRONT || mode_reg == MODE_UP_ONE);
    assign stat.action      = act_reg;

    assign mem_we  = cmd.wr_cur | cmd.put;
    assign mem_re  = cmd.rd_cur | cmd.rd_prev | cmd.rd_next;
    assign wr_addr = base_reg + SAW'(cursor_reg);
    assign wr_data = cmd.put ? held_reg : rd_data_reg;

    always_comb
    begin
        if (cmd.rd_prev)
        begin
            rd_addr = base_reg + SAW'(cursor_reg - FW'(1));
        end
        else if (cmd.rd_next)
        begin
            rd_addr = base_reg + SAW'(cursor_reg + FW'(1));
        end
        else
        begin
            rd_addr = base_reg + SAW'(cursor_reg);
        end
    end

    assign commit   = cmd.fin && (cmd.status == RS_DONE)
                      && (act_reg == ACT_INSERT || act_reg == ACT_REMOVE);
    assign fill_new = (act_reg == ACT_REMOVE) ? fill_reg - FW'(1)
                    : (evict ? fill_reg : fill_reg + FW'(1));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
        if (commit)
        begin
            fill_mem[bucket_reg] <= fill_new;
        end
        if (cmd.hash)
        begin
            fill_q_reg <= fill_mem[bucket_c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tsl_reg        <= TABLE_SIZE_RESET;
            cap_reg        <= '0;
            mode_reg       <= '0;
            item_count_reg <= '0;
            done_reg       <= 1'b0;
            vld_q_reg      <= 1'b0;
            for (int i = 0; i < NUM_BUCKETS; i++)
            begin
                fill_vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            done_reg <= cmd.fin;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TABLE_SIZE: tsl_reg  <= cfg_data;
                    CFG_BUCKET_CAP: cap_reg  <= cfg_data;
                    CFG_REORDER:    mode_reg <= cfg_data[1:0];
                    default:        ;
                endcase
            end
            if (cmd.hash)
            begin
                vld_q_reg <= fill_vld_reg[bucket_c];
            end
            if (commit)
            begin
                fill_vld_reg[bucket_reg] <= 1'b1;
                if (act_reg == ACT_INSERT)
                begin
                    if (!evict)
                    begin
                        item_count_reg <= item_count_reg + CNTW'(1);
                    end
                end
                else if (item_count_reg != '0)
                begin
                    item_count_reg <= item_count_reg - CNTW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg  <= request.action;
            key_reg  <= soht_key_mask(request.key_chars, len_in);
            len_reg  <= len_in;
            val_reg  <= request.value_in;
            hash_reg <= HASH_W'(soht_lower(request.key_chars[7:0]));
            hidx_reg <= LEN_W'(1);
        end
        else if (cmd.hash_step)
        begin
            hash_reg <= (hash_reg >> 1) + HASH_W'(soht_lower(hash_byte))
                        + (hash_reg[0] ? HASH_W'(HASH_ODD_ADD) : HASH_W'(0));
            hidx_reg <= hidx_reg + LEN_W'(1);
        end
        if (cmd.hash)
        begin
            bucket_reg <= bucket_c;
        end
        if (cmd.fill_cap)
        begin
            fill_reg <= vld_q_reg ? fill_q_reg : '0;
            base_reg <= SAW'(bucket_reg) * DEPTH_S;
        end
        if (cmd.cur_clr)
        begin
            cursor_reg <= '0;
        end
        else if (cmd.cur_inc)
        begin
            cursor_reg <= cursor_reg + FW'(1);
        end
        else if (cmd.cur_dec)
        begin
            cursor_reg <= cursor_reg - FW'(1);
        end
        else if (cmd.setup_hit)
        begin
            cursor_reg <= pos_reg;
        end
        else if (cmd.setup_ins)
        begin
            cursor_reg <= keep;
        end
        if (cmd.hit_cap)
        begin
            held_reg    <= rd_data_reg;
            old_val_reg <= rd_data_reg.value;
            pos_reg     <= cursor_reg;
        end
        if (cmd.setup_hit)
        begin
            if (pos_reg != '0 && mode_reg == MODE_TO_FRONT)
            begin
                lo_reg <= '0;
            end
            else if (pos_reg != '0 && mode_reg == MODE_UP_ONE)
            begin
                lo_reg <= pos_reg - FW'(1);
            end
            else
            begin
                lo_reg <= pos_reg;
            end
            if (act_reg == ACT_REPLACE)
            begin
                held_reg.value <= val_reg;
            end
        end
        if (cmd.setup_ins)
        begin
            lo_reg         <= '0;
            held_reg.key   <= key_reg;
            held_reg.len   <= len_reg;
            held_reg.value <= val_reg;
        end
        if (cmd.fin)
        begin
            res_reg.status    <= cmd.status;
            res_reg.value_out <= (cmd.status == RS_DONE && act_reg != ACT_INSERT)
                                 ? old_val_reg : '0;
            res_reg.evicted   <= (cmd.status == RS_DONE) && (act_reg == ACT_INSERT) && evict;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* hw/rtl/self_organizing_hash_table_unit.sv */
// Channel   Ports                          Transaction taken when
// request   start, busy, request           start high and busy low
// result    done, result                   done high (one cycle, no stall)
// config    cfg_we, cfg_index, cfg_data    cfg_we high
//
// From accept to the done strobe a request passes the hash and fill states and, as
// needed, the search and shift states. The hash folds one key byte per cycle after
// the first; each slot scanned takes a read and a compare state, each slot moved a
// read and a write state. busy falls in the cycle that shows the result.
// Reset clears control, configuration and the per-bucket fill valid bits; no
// clearing pass is needed. The receiver cannot stall the result.
module self_organizing_hash_table_unit
    import soht_pkg::*;
#(
    parameter int NUM_BUCKETS  = SOHT_NUM_BUCKETS,
    parameter int BUCKET_DEPTH = SOHT_BUCKET_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  req_t                  request,
    output logic                  busy,
    output logic                  done,
    output res_t                  result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    soht_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    soht_dp #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .BUCKET_DEPTH (BUCKET_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

/* hw/rtl/soht_check.sv */
module soht_check
    import soht_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input res_t result
);

    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> done)
        else $error("busy dropped without a result");

    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result shown while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != RS_DONE) |-> (result.value_out == '0 && !result.evicted))
        else $error("failed transaction carries a value or eviction");

endmodule

bind self_organizing_hash_table_unit soht_check u_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
